FILE: rtl/rrps_pkg.sv
package rrps_pkg;

   // slave table
   localparam int MAX_SLAVES = 16;
   localparam int SLAVE_W    = $clog2(MAX_SLAVES);
   localparam int COUNT_W    = $clog2(MAX_SLAVES + 1);

   // timers
   localparam int          TIMER_W     = 16;
   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
   localparam logic [15:0] RETRY_EARLY = 16'd5;

   // register file
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int SLV_CNT_W  = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_POLL_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_COUNT   = 2'd3;

   localparam logic [15:0]          POLL_INTERVAL_RST = 16'd100;
   localparam logic [15:0]          READ_TIMEOUT_RST  = 16'd50;
   localparam logic [15:0]          RECOVERY_RST      = 16'd100;
   localparam logic [SLV_CNT_W-1:0] SLAVE_COUNT_RST   = 5'd1;

   // event codes
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_READ_DONE = 2'd1;
   localparam logic [1:0] OP_BUS_ERROR = 2'd2;
   localparam logic [1:0] OP_SET_EN    = 2'd3;

   // action codes
   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_START    = 3'd1;
   localparam logic [2:0] ACT_ABORT    = 3'd2;
   localparam logic [2:0] ACT_HANDOVER = 3'd3;
   localparam logic [2:0] ACT_REINIT   = 3'd4;

   // phase codes as seen on the result channel
   localparam logic [1:0] PHASE_IDLE       = 2'd0;
   localparam logic [1:0] PHASE_READING    = 2'd1;
   localparam logic [1:0] PHASE_PROCESSING = 2'd2;
   localparam logic [1:0] PHASE_ERROR      = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [SLAVE_W-1:0] slave_index;
      logic               enable_value;
      logic               bus_taken_by_other;
      logic               controller_ready;
      logic               start_accepted;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [SLAVE_W-1:0] action_slave;
      logic [1:0]         phase;
      logic               bus_held;
      logic               accepted;
   } rsp_item_type;

   typedef struct packed {
      logic [TIMER_W-1:0] poll_interval;
      logic [TIMER_W-1:0] read_timeout;
      logic [TIMER_W-1:0] recovery;
      logic [COUNT_W-1:0] used_count;
   } csr_set_type;

   typedef struct packed {
      logic               found;
      logic [SLAVE_W-1:0] slave;
   } pick_type;

   // remainder of a small numerator (up to MAX_SLAVES) by a small count
   function automatic logic [SLAVE_W-1:0] mod_small(input logic [COUNT_W-1:0] num,
                                                    input logic [COUNT_W-1:0] den);
      logic [2*COUNT_W-1:0] prod;
      logic [2*COUNT_W-1:0] diff;
      logic [SLAVE_W-1:0]   rem;
      rem = '0;
      for (int q = 0; q <= MAX_SLAVES; q++) begin
         prod = (2*COUNT_W)'(q) * {{COUNT_W{1'b0}}, den};
         diff = {{COUNT_W{1'b0}}, num} - prod;
         if ({{COUNT_W{1'b0}}, num} >= prod && diff < {{COUNT_W{1'b0}}, den}) begin
            rem = diff[SLAVE_W-1:0];
         end
      end
      return rem;
   endfunction

endpackage

FILE: rtl/rrps_if.sv
interface rrps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [3:0] slave_index;
   logic       enable_value;
   logic       bus_taken_by_other;
   logic       controller_ready;
   logic       start_accepted;

   modport source (output valid, output op, output slave_index, output enable_value,
                   output bus_taken_by_other, output controller_ready,
                   output start_accepted, input ready);
   modport sink   (input valid, input op, input slave_index, input enable_value,
                   input bus_taken_by_other, input controller_ready,
                   input start_accepted, output ready);
endinterface

interface rrps_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [3:0] action_slave;
   logic [1:0] phase;
   logic       bus_held;
   logic       accepted;

   modport source (output valid, output action, output action_slave, output phase,
                   output bus_held, output accepted, input ready);
   modport sink   (input valid, input action, input action_slave, input phase,
                   input bus_held, input accepted, output ready);
endinterface

FILE: rtl/rrps_pick.sv
module rrps_pick (
   input  logic [rrps_pkg::MAX_SLAVES-1:0] enable_map,
   input  logic [rrps_pkg::COUNT_W-1:0]    used_count,
   input  logic [rrps_pkg::SLAVE_W-1:0]    active_slave,
   input  logic                            active_valid,
   output rrps_pkg::pick_type              pick
);
   import rrps_pkg::*;

   logic [SLAVE_W-1:0]    start;
   logic [MAX_SLAVES-1:0] cand_all;
   logic [MAX_SLAVES-1:0] cand_hi;
   logic [SLAVE_W-1:0]    hi_idx;
   logic [SLAVE_W-1:0]    lo_idx;

   // round-robin start: one past the last active slave, wrapped by the count
   always_comb begin
      if (active_valid && used_count != '0) begin
         start = mod_small({1'b0, active_slave} + COUNT_W'(1), used_count);
      end else begin
         start = '0;
      end
   end

   // lowest enabled entry at or after start, else lowest enabled overall
   always_comb begin
      hi_idx = '0;
      lo_idx = '0;
      for (int i = 0; i < MAX_SLAVES; i++) begin
         cand_all[i] = enable_map[i] && (COUNT_W'(i) < used_count);
         cand_hi[i]  = cand_all[i] && (SLAVE_W'(i) >= start);
      end
      for (int i = MAX_SLAVES - 1; i >= 0; i--) begin
         if (cand_hi[i]) begin
            hi_idx = SLAVE_W'(i);
         end
         if (cand_all[i]) begin
            lo_idx = SLAVE_W'(i);
         end
      end
      pick.found = |cand_all;
      if (|cand_hi) begin
         pick.slave = hi_idx;
      end else if (|cand_all) begin
         pick.slave = lo_idx;
      end else begin
         pick.slave = start;
      end
   end

endmodule

FILE: rtl/rrps_engine.sv
module rrps_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  rrps_pkg::req_item_type item,
   input  rrps_pkg::csr_set_type  csr,
   input  logic                   rsp_ready,
   output logic                   take,
   output logic                   rsp_valid,
   output rrps_pkg::rsp_item_type result
);
   import rrps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE       = PHASE_IDLE,
      ST_READING    = PHASE_READING,
      ST_PROCESSING = PHASE_PROCESSING,
      ST_ERROR      = PHASE_ERROR
   } state_type;

   state_type             state_ff, state_in;
   logic [SLAVE_W-1:0]    active_slave_ff, active_slave_in;
   logic                  active_valid_ff, active_valid_in;
   logic [TIMER_W-1:0]    poll_elapsed_ff, poll_elapsed_in;
   logic [TIMER_W-1:0]    phase_elapsed_ff, phase_elapsed_in;
   logic [MAX_SLAVES-1:0] enable_map_ff, enable_map_in;
   logic                  lock_ff, lock_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          result_ff, result_in;

   pick_type           pick;
   logic               fire;
   logic [TIMER_W-1:0] poll_inc;
   logic [TIMER_W-1:0] phase_inc;
   logic [TIMER_W-1:0] retry_value;
   logic               refused;

   rrps_pick u_pick (
      .enable_map   (enable_map_ff),
      .used_count   (csr.used_count),
      .active_slave (active_slave_ff),
      .active_valid (active_valid_ff),
      .pick         (pick)
   );

   assign take      = !rsp_valid_ff || rsp_ready;
   assign fire      = item_valid && take;
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   assign poll_inc    = (poll_elapsed_ff == ELAPSED_MAX) ? poll_elapsed_ff
                                                         : poll_elapsed_ff + TIMER_W'(1);
   assign phase_inc   = (phase_elapsed_ff == ELAPSED_MAX) ? phase_elapsed_ff
                                                          : phase_elapsed_ff + TIMER_W'(1);
   assign retry_value = (csr.poll_interval >= RETRY_EARLY) ? csr.poll_interval - RETRY_EARLY
                                                           : '0;

   always_comb begin
      state_in         = state_ff;
      active_slave_in  = active_slave_ff;
      active_valid_in  = active_valid_ff;
      poll_elapsed_in  = poll_elapsed_ff;
      phase_elapsed_in = phase_elapsed_ff;
      enable_map_in    = enable_map_ff;
      lock_in          = lock_ff;
      refused          = 1'b0;
      result_in.action       = ACT_NONE;
      result_in.action_slave = '0;
      result_in.accepted     = 1'b1;

      case (item.op)
         OP_TICK: begin
            poll_elapsed_in  = poll_inc;
            phase_elapsed_in = phase_inc;
            case (state_ff)
               ST_IDLE: begin
                  if (poll_inc >= csr.poll_interval) begin
                     if (!pick.found) begin
                        refused = 1'b1;
                     end else if (!lock_ff && item.bus_taken_by_other) begin
                        refused = 1'b1;
                     end else if (!item.controller_ready) begin
                        lock_in = 1'b0;
                        refused = 1'b1;
                     end else begin
                        active_slave_in  = pick.slave;
                        phase_elapsed_in = '0;
                        if (!item.start_accepted) begin
                           state_in        = ST_ERROR;
                           active_valid_in = 1'b0;
                           lock_in         = 1'b0;
                           refused         = 1'b1;
                        end else begin
                           state_in               = ST_READING;
                           active_valid_in        = 1'b1;
                           lock_in                = 1'b1;
                           poll_elapsed_in        = '0;
                           result_in.action       = ACT_START;
                           result_in.action_slave = pick.slave;
                        end
                     end
                     if (refused) begin
                        poll_elapsed_in = retry_value;
                     end
                  end
               end
               ST_READING: begin
                  if (phase_inc > csr.read_timeout) begin
                     if ({1'b0, active_slave_ff} < csr.used_count) begin
                        result_in.action       = ACT_ABORT;
                        result_in.action_slave = active_slave_ff;
                     end
                     state_in         = ST_ERROR;
                     phase_elapsed_in = '0;
                     active_valid_in  = 1'b0;
                     lock_in          = 1'b0;
                  end
               end
               ST_PROCESSING: begin
                  if (active_valid_ff && {1'b0, active_slave_ff} < csr.used_count) begin
                     result_in.action       = ACT_HANDOVER;
                     result_in.action_slave = active_slave_ff;
                  end
                  state_in = ST_IDLE;
                  lock_in  = 1'b0;
               end
               ST_ERROR: begin
                  if (phase_inc > csr.recovery) begin
                     result_in.action = ACT_REINIT;
                     state_in         = ST_IDLE;
                     active_valid_in  = 1'b0;
                     lock_in          = 1'b0;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         OP_READ_DONE: begin
            if (state_ff == ST_READING) begin
               state_in = ST_PROCESSING;
            end else begin
               result_in.accepted = 1'b0;
            end
         end
         OP_BUS_ERROR: begin
            state_in         = ST_ERROR;
            phase_elapsed_in = '0;
            active_valid_in  = 1'b0;
            lock_in          = 1'b0;
         end
         OP_SET_EN: begin
            if ({1'b0, item.slave_index} < csr.used_count) begin
               enable_map_in[item.slave_index] = item.enable_value;
            end else begin
               result_in.accepted = 1'b0;
            end
         end
         default: begin
            result_in.accepted = 1'b0;
         end
      endcase

      result_in.phase    = state_in;
      result_in.bus_held = lock_in;

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         active_slave_ff  <= '0;
         active_valid_ff  <= 1'b0;
         poll_elapsed_ff  <= '0;
         phase_elapsed_ff <= '0;
         enable_map_ff    <= '0;
         lock_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff         <= state_in;
            active_slave_ff  <= active_slave_in;
            active_valid_ff  <= active_valid_in;
            poll_elapsed_ff  <= poll_elapsed_in;
            phase_elapsed_ff <= phase_elapsed_in;
            enable_map_ff    <= enable_map_in;
            lock_ff          <= lock_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

endmodule

FILE: rtl/round_robin_poll_sequencer_unit.sv
// Round-robin poll sequencer: each transfer on the request channel is one event (millisecond
// tick, read done, bus error or slave enable write) and yields exactly one transfer on the
// response channel carrying the action taken, the slave it concerns, the phase and bus lock
// after the event, and whether the event took effect. One event is taken every clock cycle
// while the response channel keeps up; an event passes through the input register and then
// the state update that loads the result register, and the single update of the sequencer
// state per cycle sets that rate. The input register can take a new event while a result waits
// for its transfer. Registers are written through csr_we / csr_index / csr_wdata and must only
// change while no event is in flight. After reset all slaves are disabled and no clearing
// pass is needed.
module round_robin_poll_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   rrps_req_if.sink                         req_chan,
   rrps_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [rrps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrps_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rrps_pkg::*;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type item_ff;
   req_item_type req_item;
   logic         req_take;

   // configuration registers
   logic [TIMER_W-1:0]   poll_interval_ff;
   logic [TIMER_W-1:0]   read_timeout_ff;
   logic [TIMER_W-1:0]   recovery_ff;
   logic [SLV_CNT_W-1:0] slave_count_ff;
   csr_set_type          csr_set;

   // engine handshake
   logic         take;
   logic         rsp_valid;
   rsp_item_type result;

   // input stage frees up whenever the engine takes its item
   assign req_chan.ready = !in_valid_ff || take;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign req_item.op                 = req_chan.op;
   assign req_item.slave_index        = req_chan.slave_index;
   assign req_item.enable_value       = req_chan.enable_value;
   assign req_item.bus_taken_by_other = req_chan.bus_taken_by_other;
   assign req_item.controller_ready   = req_chan.controller_ready;
   assign req_item.start_accepted     = req_chan.start_accepted;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_item;
      end
   end

   // register file, write only
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff <= POLL_INTERVAL_RST;
         read_timeout_ff  <= READ_TIMEOUT_RST;
         recovery_ff      <= RECOVERY_RST;
         slave_count_ff   <= SLAVE_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLL_INTERVAL: poll_interval_ff <= csr_wdata;
            CSR_READ_TIMEOUT:  read_timeout_ff  <= csr_wdata;
            CSR_RECOVERY:      recovery_ff      <= csr_wdata;
            CSR_SLAVE_COUNT:   slave_count_ff   <= csr_wdata[SLV_CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // counts above the table size saturate to the table size
   assign csr_set.poll_interval = poll_interval_ff;
   assign csr_set.read_timeout  = read_timeout_ff;
   assign csr_set.recovery      = recovery_ff;
   assign csr_set.used_count    = (slave_count_ff > SLV_CNT_W'(MAX_SLAVES))
                                  ? COUNT_W'(MAX_SLAVES) : COUNT_W'(slave_count_ff);

   rrps_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item       (item_ff),
      .csr        (csr_set),
      .rsp_ready  (rsp_chan.ready),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .result     (result)
   );

   // response channel straight from the result register
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.action       = result.action;
   assign rsp_chan.action_slave = result.action_slave;
   assign rsp_chan.phase        = result.phase;
   assign rsp_chan.bus_held     = result.bus_held;
   assign rsp_chan.accepted     = result.accepted;

endmodule

FILE: rtl/rrps_checker.sv
module rrps_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_action,
   input logic [1:0] rsp_phase,
   input logic       rsp_bus_held
);
   import rrps_pkg::*;

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) && $stable(rsp_phase))
      else $error("stalled response changed");

   // a started read owns the bus and is reading
   a_start_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_START |-> rsp_phase == PHASE_READING && rsp_bus_held)
      else $error("start without reading phase and lock");

   // abort always ends in error with the lock dropped
   a_abort_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_ABORT |-> rsp_phase == PHASE_ERROR && !rsp_bus_held)
      else $error("abort not leading to error");

   // the lock is never held in error or after a hand-over / reinit
   a_lock_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PHASE_ERROR || rsp_action == ACT_HANDOVER ||
                    rsp_action == ACT_REINIT) |-> !rsp_bus_held)
      else $error("bus lock held when it must be released");

endmodule

bind round_robin_poll_sequencer_unit rrps_checker u_rrps_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_action   (rsp_chan.action),
   .rsp_phase    (rsp_chan.phase),
   .rsp_bus_held (rsp_chan.bus_held)
);

FILE: tb/sv/round_robin_poll_sequencer_unit_tb.sv
`timescale 1ns / 1ps

module round_robin_poll_sequencer_unit_tb;
   import rrps_pkg::*;

   // generous ceiling on the whole run, in clock cycles
   localparam int CYCLE_LIMIT = 200_000;
   // receiver hold-off used to back the block up into its input
   localparam int HOLD_OFF_CYCLES = 80;

   // one line of the directed script: either a register write or an event,
   // optionally with the result typed in by hand
   typedef struct packed {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] csr_sel;
      logic [15:0]          csr_val;
      req_item_type         item;
      logic                 typed;
      rsp_item_type         want;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rrps_req_if req_bus ();
   rrps_rsp_if rsp_bus ();

   round_robin_poll_sequencer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // pacing knobs: percent of cycles spent idle or stalled, plus the receiver hold-off
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_cycles   = 0;

   int mismatch_count = 0;
   int cycle_count    = 0;

   // results still owed by the block, oldest first
   rsp_item_type pending_results[$];

   // register copies kept by the predictor
   logic [15:0]          cfg_interval;
   logic [15:0]          cfg_timeout;
   logic [15:0]          cfg_recovery;
   logic [SLV_CNT_W-1:0] cfg_count;

   // sequencer state as the predictor sees it
   logic [1:0]            sq_phase;
   logic [SLAVE_W-1:0]    sq_slave;
   logic                  sq_slave_valid;
   logic [15:0]           poll_el;
   logic [15:0]           phase_el;
   logic [MAX_SLAVES-1:0] en_map;
   logic                  sq_lock;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // hard stop if the run hangs anywhere
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      mismatch_count = mismatch_count + 1;
   endtask

   task automatic compare_field(input string name, input logic [3:0] got,
                                input logic [3:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic reset_sequencer_model();
      cfg_interval   = POLL_INTERVAL_RST;
      cfg_timeout    = READ_TIMEOUT_RST;
      cfg_recovery   = RECOVERY_RST;
      cfg_count      = SLAVE_COUNT_RST;
      sq_phase       = PHASE_IDLE;
      sq_slave       = '0;
      sq_slave_valid = 1'b0;
      poll_el        = '0;
      phase_el       = '0;
      en_map         = '0;
      sq_lock        = 1'b0;
   endtask

   function automatic logic [15:0] sat_up(input logic [15:0] v);
      return (v == ELAPSED_MAX) ? v : v + 16'd1;
   endfunction

   // common exit into the error phase: timer restarts, slave and lock dropped
   function automatic void fall_into_error();
      sq_phase       = PHASE_ERROR;
      phase_el       = '0;
      sq_slave_valid = 1'b0;
      sq_lock        = 1'b0;
   endfunction

   // advances the sequencer by one event and returns the result it should show
   function automatic rsp_item_type step_sequencer(input req_item_type item);
      rsp_item_type r;
      int           n;
      int           pick;
      bit           found;
      bit           refused;
      r          = '0;
      r.accepted = 1'b1;
      n = (cfg_count > MAX_SLAVES) ? MAX_SLAVES : int'(cfg_count);
      case (item.op)
         OP_TICK: begin
            poll_el  = sat_up(poll_el);
            phase_el = sat_up(phase_el);
            case (sq_phase)
               PHASE_IDLE: begin
                  if (poll_el >= cfg_interval) begin
                     refused = 1'b1;
                     if (n != 0) begin
                        // round-robin search from the slave after the last one
                        pick  = sq_slave_valid ? (int'(sq_slave) + 1) % n : 0;
                        found = 1'b0;
                        for (int k = 0; k < n; k++) begin
                           if (!found) begin
                              if (en_map[pick]) found = 1'b1;
                              else pick = (pick + 1) % n;
                           end
                        end
                        if (en_map[pick] && !(!sq_lock && item.bus_taken_by_other)) begin
                           sq_lock = 1'b1;
                           if (!item.controller_ready) begin
                              sq_lock = 1'b0;
                           end else begin
                              sq_slave       = pick[SLAVE_W-1:0];
                              sq_slave_valid = 1'b1;
                              phase_el       = '0;
                              sq_phase       = PHASE_READING;
                              if (!item.start_accepted) begin
                                 fall_into_error();
                              end else begin
                                 poll_el        = '0;
                                 r.action       = ACT_START;
                                 r.action_slave = pick[SLAVE_W-1:0];
                                 refused        = 1'b0;
                              end
                           end
                        end
                     end
                     // a refused start retries a little sooner than a full interval
                     if (refused)
                        poll_el = (cfg_interval >= RETRY_EARLY) ? cfg_interval - RETRY_EARLY : '0;
                  end
               end
               PHASE_READING: begin
                  if (phase_el > cfg_timeout) begin
                     if (int'(sq_slave) < n) begin
                        r.action       = ACT_ABORT;
                        r.action_slave = sq_slave;
                     end
                     fall_into_error();
                  end
               end
               PHASE_PROCESSING: begin
                  if (sq_slave_valid && int'(sq_slave) < n) begin
                     r.action       = ACT_HANDOVER;
                     r.action_slave = sq_slave;
                  end
                  sq_phase = PHASE_IDLE;
                  sq_lock  = 1'b0;
               end
               default: begin
                  if (phase_el > cfg_recovery) begin
                     r.action       = ACT_REINIT;
                     sq_phase       = PHASE_IDLE;
                     sq_slave_valid = 1'b0;
                     sq_lock        = 1'b0;
                  end
               end
            endcase
         end
         OP_READ_DONE: begin
            if (sq_phase == PHASE_READING) sq_phase = PHASE_PROCESSING;
            else r.accepted = 1'b0;
         end
         OP_BUS_ERROR: begin
            fall_into_error();
         end
         default: begin
            if (int'(item.slave_index) < n) en_map[item.slave_index] = item.enable_value;
            else r.accepted = 1'b0;
         end
      endcase
      r.phase    = sq_phase;
      r.bus_held = sq_lock;
      return r;
   endfunction

   function automatic req_item_type make_event(input logic [1:0] op,
                                               input logic [SLAVE_W-1:0] idx,
                                               input logic en, input logic busy,
                                               input logic rdy, input logic acc);
      req_item_type e;
      e.op                 = op;
      e.slave_index        = idx;
      e.enable_value       = en;
      e.bus_taken_by_other = busy;
      e.controller_ready   = rdy;
      e.start_accepted     = acc;
      return e;
   endfunction

   function automatic rsp_item_type make_result(input logic [2:0] action,
                                                input logic [SLAVE_W-1:0] slave,
                                                input logic [1:0] phase,
                                                input logic held, input logic acc);
      rsp_item_type r;
      r.action       = action;
      r.action_slave = slave;
      r.phase        = phase;
      r.bus_held     = held;
      r.accepted     = acc;
      return r;
   endfunction

   function automatic script_row_type event_row(input req_item_type item);
      script_row_type row;
      row      = '0;
      row.item = item;
      return row;
   endfunction

   function automatic script_row_type typed_row(input req_item_type item,
                                                input rsp_item_type want);
      script_row_type row;
      row       = '0;
      row.item  = item;
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic script_row_type csr_row(input logic [CSR_IDX_W-1:0] sel,
                                              input logic [15:0] val);
      script_row_type row;
      row         = '0;
      row.is_csr  = 1'b1;
      row.csr_sel = sel;
      row.csr_val = val;
      return row;
   endfunction

   // mostly well-formed traffic: ticks dominate, reads get completed, starts
   // usually go through; noisy mode draws every field uniformly
   function automatic req_item_type random_event(input bit noisy);
      req_item_type e;
      int           roll;
      if (noisy) begin
         e.op                 = 2'($urandom_range(3));
         e.enable_value       = 1'($urandom_range(1));
         e.bus_taken_by_other = 1'($urandom_range(1));
         e.controller_ready   = 1'($urandom_range(1));
         e.start_accepted     = 1'($urandom_range(1));
      end else begin
         roll = $urandom_range(99);
         if (roll < 70)      e.op = OP_TICK;
         else if (roll < 82) e.op = OP_READ_DONE;
         else if (roll < 85) e.op = OP_BUS_ERROR;
         else                e.op = OP_SET_EN;
         e.enable_value       = ($urandom_range(99) < 70);
         e.bus_taken_by_other = ($urandom_range(99) < 12);
         e.controller_ready   = ($urandom_range(99) >= 10);
         e.start_accepted     = ($urandom_range(99) >= 10);
      end
      e.slave_index = SLAVE_W'($urandom_range(MAX_SLAVES - 1));
      return e;
   endfunction

   // offers one event, waits for the transfer and records what should come back
   task automatic send_item(input req_item_type item, input bit use_typed,
                            input rsp_item_type typed_want);
      rsp_item_type want;
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid              = 1'b1;
      req_bus.op                 = item.op;
      req_bus.slave_index        = item.slave_index;
      req_bus.enable_value       = item.enable_value;
      req_bus.bus_taken_by_other = item.bus_taken_by_other;
      req_bus.controller_ready   = item.controller_ready;
      req_bus.start_accepted     = item.start_accepted;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      want = step_sequencer(item);
      if (use_typed) want = typed_want;
      pending_results.push_back(want);
      @(negedge clock);
   endtask

   task automatic send_event(input req_item_type item);
      send_item(item, 1'b0, '0);
   endtask

   // stop offering and let every owed result come out
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] sel, input logic [15:0] val);
      wait_drained();
      // nothing left in flight after the last result, small margin anyway
      repeat (2) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = sel;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (sel)
         CSR_POLL_INTERVAL: cfg_interval = val;
         CSR_READ_TIMEOUT:  cfg_timeout  = val;
         CSR_RECOVERY:      cfg_recovery = val;
         default:           cfg_count    = val[SLV_CNT_W-1:0];
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] interval, input logic [15:0] timeout,
                                 input logic [15:0] recovery, input logic [15:0] count);
      write_register(CSR_POLL_INTERVAL, interval);
      write_register(CSR_READ_TIMEOUT, timeout);
      write_register(CSR_RECOVERY, recovery);
      write_register(CSR_SLAVE_COUNT, count);
   endtask

   // one random phase; pressure adds a long receiver hold-off at the start and
   // a full drain halfway through
   task automatic run_phase(input logic [15:0] interval, input logic [15:0] timeout,
                            input logic [15:0] recovery, input logic [15:0] count,
                            input int items, input int idle_pct, input int stall_pct,
                            input bit noisy, input bit pressure);
      apply_settings(interval, timeout, recovery, count);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      if (pressure) hold_cycles = HOLD_OFF_CYCLES;
      for (int i = 0; i < items; i++) begin
         if (pressure && i == items / 2) wait_drained();
         send_event(random_event(noisy));
      end
      wait_drained();
   endtask

   // top of the timer range: longest recovery, interval and timeout hold the
   // sequencer where it is; dropping each limit then lets the event through
   task automatic run_long_timers();
      req_item_type good_tick;
      good_tick = make_event(OP_TICK, '0, 1'b0, 1'b0, 1'b1, 1'b1);
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < MAX_SLAVES; i++)
         send_event(make_event(OP_SET_EN, SLAVE_W'(i), 1'b1, 1'b0, 1'b1, 1'b1));
      // known starting point: error that the longest recovery keeps
      send_event(make_event(OP_BUS_ERROR, '0, 1'b0, 1'b0, 1'b1, 1'b1));
      for (int i = 0; i < 20; i++) send_event(good_tick);
      write_register(CSR_RECOVERY, 16'd0);
      send_event(good_tick);
      // longest interval: no poll yet
      for (int i = 0; i < 20; i++) send_event(good_tick);
      write_register(CSR_POLL_INTERVAL, 16'd5);
      send_event(good_tick);
      // longest timeout: the read keeps running
      for (int i = 0; i < 10; i++) send_event(good_tick);
      write_register(CSR_READ_TIMEOUT, 16'd0);
      send_event(good_tick);
      wait_drained();
   endtask

   // receiver pacing, with the long hold-off counted here
   initial begin : rsp_pacer
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            hold_cycles   = hold_cycles - 1;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // every result transfer is matched against the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_error($sformatf("result with nothing expected: action %0d slave %0d",
                                   rsp_bus.action, rsp_bus.action_slave));
         end else begin
            want = pending_results.pop_front();
            compare_field("action", {1'b0, rsp_bus.action}, {1'b0, want.action});
            compare_field("action_slave", rsp_bus.action_slave, want.action_slave);
            compare_field("phase", {2'b00, rsp_bus.phase}, {2'b00, want.phase});
            compare_field("bus_held", {3'b000, rsp_bus.bus_held}, {3'b000, want.bus_held});
            compare_field("accepted", {3'b000, rsp_bus.accepted}, {3'b000, want.accepted});
         end
      end
   end

   initial begin : stimulus
      script_row_type directed_rows[$];
      req_item_type tick;

      // everything driven from time zero
      reset                      = 1'b1;
      csr_we                     = 1'b0;
      csr_index                  = '0;
      csr_wdata                  = '0;
      req_bus.valid              = 1'b0;
      req_bus.op                 = OP_TICK;
      req_bus.slave_index        = '0;
      req_bus.enable_value       = 1'b0;
      req_bus.bus_taken_by_other = 1'b0;
      req_bus.controller_ready   = 1'b0;
      req_bus.start_accepted     = 1'b0;
      reset_sequencer_model();

      tick = make_event(OP_TICK, '0, 1'b0, 1'b0, 1'b1, 1'b1);

      // reset values first: slow interval, one slave, all disabled
      directed_rows.push_back(typed_row(tick,
         make_result(ACT_NONE, '0, PHASE_IDLE, 1'b0, 1'b1)));
      // read done while idle is ignored
      directed_rows.push_back(typed_row(make_event(OP_READ_DONE, '0, 1'b0, 1'b0, 1'b1, 1'b1),
         make_result(ACT_NONE, '0, PHASE_IDLE, 1'b0, 1'b0)));
      // enable write beyond the slave count is rejected
      directed_rows.push_back(typed_row(make_event(OP_SET_EN, 4'd1, 1'b1, 1'b0, 1'b1, 1'b1),
         make_result(ACT_NONE, '0, PHASE_IDLE, 1'b0, 1'b0)));
      directed_rows.push_back(typed_row(make_event(OP_BUS_ERROR, 4'd15, 1'b1, 1'b1, 1'b0, 1'b0),
         make_result(ACT_NONE, '0, PHASE_ERROR, 1'b0, 1'b1)));
      // short timers and the full slave table
      directed_rows.push_back(csr_row(CSR_POLL_INTERVAL, 16'd5));
      directed_rows.push_back(csr_row(CSR_READ_TIMEOUT, 16'd3));
      directed_rows.push_back(csr_row(CSR_RECOVERY, 16'd0));
      directed_rows.push_back(csr_row(CSR_SLAVE_COUNT, 16'd16));
      // zero recovery: reinit on the first tick in error
      directed_rows.push_back(typed_row(tick,
         make_result(ACT_REINIT, '0, PHASE_IDLE, 1'b0, 1'b1)));
      directed_rows.push_back(typed_row(make_event(OP_SET_EN, 4'd15, 1'b1, 1'b0, 1'b1, 1'b1),
         make_result(ACT_NONE, '0, PHASE_IDLE, 1'b0, 1'b1)));
      directed_rows.push_back(typed_row(make_event(OP_SET_EN, 4'd0, 1'b1, 1'b0, 1'b1, 1'b1),
         make_result(ACT_NONE, '0, PHASE_IDLE, 1'b0, 1'b1)));
      // poll interval reached: start on slave 0
      repeat (3) directed_rows.push_back(event_row(tick));
      // completed read, handed over on the next tick
      directed_rows.push_back(event_row(make_event(OP_READ_DONE, 4'd3, 1'b0, 1'b1, 1'b0, 1'b0)));
      directed_rows.push_back(event_row(tick));
      // next poll searches from slave 1 and lands on slave 15
      repeat (4) directed_rows.push_back(event_row(tick));
      // read left running past the timeout gets aborted, then recovery
      repeat (5) directed_rows.push_back(event_row(tick));
      directed_rows.push_back(event_row(make_event(OP_BUS_ERROR, 4'd15, 1'b1, 1'b1, 1'b1, 1'b1)));
      directed_rows.push_back(event_row(make_event(OP_SET_EN, 4'd15, 1'b0, 1'b1, 1'b1, 1'b1)));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr)
            write_register(directed_rows[i].csr_sel, directed_rows[i].csr_val);
         else
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
      wait_drained();

      // random phases: pacing, counts and timers vary from phase to phase
      run_phase(16'd5, 16'd8, 16'd3, 16'd16, 200, 0, 0, 1'b0, 1'b0);
      run_phase(16'd7, 16'd0, 16'd0, 16'd4, 180, 83, 0, 1'b0, 1'b0);
      run_phase(16'd5, 16'd20, 16'd10, 16'd1, 150, 0, 83, 1'b0, 1'b0);
      // zero slaves: every poll refused, every enable write rejected
      run_phase(16'd6, 16'd5, 16'd2, 16'd0, 80, 12, 12, 1'b0, 1'b0);
      // count above the table size saturates; receiver backs the block up
      run_phase(16'd5, 16'd3, 16'd2, 16'd31, 150, 12, 12, 1'b0, 1'b1);
      run_phase(16'd5, 16'd2, 16'd1, 16'd9, 120, 0, 0, 1'b1, 1'b0);
      run_long_timers();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
